// File: hw/rtl/bbct_pkg.sv
// Package for the disc contact time block: widths, register indexes and the
// side payload types that travel through the root and divider pipelines.
// No dependencies.
package bbct_pkg;

  localparam int POS_W = 24;
  localparam int DIFF_W = 25;
  localparam int SQ_W = 49;
  localparam int DOT_W = 50;
  localparam int A_W = 50;
  localparam int C_W = 51;
  localparam int AMAG_W = 49;
  localparam int CMAG_W = 50;
  localparam int MUL_W = 50;
  localparam int MH_W = 25;
  localparam int PROD_W = 100;
  localparam int D_W = 102;
  localparam int S_W = 51;
  localparam int N_W = 53;
  localparam int NMAG_W = 52;
  localparam int DEN_W = 50;
  localparam int TIME_W = 24;
  localparam int REG_W = 23;
  localparam int IDX_W = 1;
  localparam int DEFAULT_FRAC_BITS = 12;

  localparam logic [REG_W-1:0] RADIUS_RESET = 23'd40960;
  localparam logic [REG_W-1:0] TOL_RESET = 23'd4;

  typedef logic [IDX_W-1:0] reg_idx_t;
  localparam reg_idx_t REG_DISC_RADIUS = 1'b0;
  localparam reg_idx_t REG_TOUCH_TOL = 1'b1;

  typedef struct packed {
    logic signed [C_W-1:0] c;
    logic [SQ_W-1:0] vv;
    logic [TIME_W-1:0] limit;
    logic has_roots;
  } sqrt_side_t;

  typedef struct packed {
    logic [TIME_W-1:0] limit;
    logic has_roots;
    logic neg_p;
    logic neg_m;
  } div_side_t;

endpackage

// File: hw/rtl/bbct_wmul.sv
// Two-stage unsigned multiplier built from four half-width partial products.
// Depends on bbct_pkg.
module bbct_wmul (
  input  logic clk,
  input  logic en,
  input  logic [bbct_pkg::MUL_W-1:0] a,
  input  logic [bbct_pkg::MUL_W-1:0] b,
  output logic [bbct_pkg::PROD_W-1:0] p
);
  import bbct_pkg::*;

  logic [MH_W-1:0] al, ah, bl, bh;
  logic [2*MH_W-1:0] pll, plh, phl, phh;
  logic [PROD_W-1:0] p_next;

  always_comb begin
    al = a[MH_W-1:0];
    ah = a[MUL_W-1:MH_W];
    bl = b[MH_W-1:0];
    bh = b[MUL_W-1:MH_W];
    p_next = {phh, pll} + (PROD_W'(plh) << MH_W) + (PROD_W'(phl) << MH_W);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pll <= al * bl;
      plh <= al * bh;
      phl <= ah * bl;
      phh <= ah * bh;
      p <= p_next;
    end
  end

endmodule

// File: hw/rtl/bbct_sqrt.sv
// Pipelined integer square root, one result bit per stage, with side payload.
// Depends on bbct_pkg.
module bbct_sqrt (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic [bbct_pkg::D_W-1:0] d_in,
  input  bbct_pkg::sqrt_side_t side_in,
  output logic out_valid,
  output logic [bbct_pkg::S_W-1:0] root,
  output bbct_pkg::sqrt_side_t side_out
);
  import bbct_pkg::*;

  localparam int RW = S_W + 1;

  logic [RW-1:0] rem [S_W];
  logic [RW-1:0] rem_next [S_W];
  logic [S_W-1:0] q [S_W];
  logic [S_W-1:0] q_next [S_W];
  logic [D_W-1:0] dsh [S_W];
  logic [D_W-1:0] dsh_next [S_W];
  sqrt_side_t side [S_W];
  logic [S_W-1:0] vld;

  always_comb begin
    logic [RW+1:0] rem2;
    logic [RW+1:0] trial;
    logic [RW-1:0] rem_prev;
    logic [S_W-1:0] q_prev;
    logic [D_W-1:0] d_prev;
    for (int k = 0; k < S_W; k++) begin
      if (k == 0) begin
        rem_prev = '0;
        q_prev = '0;
        d_prev = d_in;
      end else begin
        rem_prev = rem[k-1];
        q_prev = q[k-1];
        d_prev = dsh[k-1];
      end
      rem2 = {rem_prev, d_prev[D_W-1 -: 2]};
      trial = {1'b0, q_prev, 2'b01};
      if (rem2 >= trial) begin
        rem_next[k] = RW'(rem2 - trial);
        q_next[k] = {q_prev[S_W-2:0], 1'b1};
      end else begin
        rem_next[k] = RW'(rem2);
        q_next[k] = {q_prev[S_W-2:0], 1'b0};
      end
      dsh_next[k] = {d_prev[D_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < S_W; k++) begin
        rem[k] <= rem_next[k];
        q[k] <= q_next[k];
        dsh[k] <= dsh_next[k];
        side[k] <= (k == 0) ? side_in : side[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[S_W-2:0], in_valid};
    end
  end

  assign out_valid = vld[S_W-1];
  assign root = q[S_W-1];
  assign side_out = side[S_W-1];

endmodule

// File: hw/rtl/bbct_div.sv
// Two-lane pipelined restoring divider sharing one denominator, one quotient
// bit per stage after the first, with an overflow flag for quotients beyond the time width.
// Depends on bbct_pkg.
module bbct_div #(
  parameter int FRAC_BITS = bbct_pkg::DEFAULT_FRAC_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic [bbct_pkg::NMAG_W-1:0] num_p,
  input  logic [bbct_pkg::NMAG_W-1:0] num_m,
  input  logic [bbct_pkg::DEN_W-1:0] den,
  input  bbct_pkg::div_side_t side_in,
  output logic out_valid,
  output logic [bbct_pkg::TIME_W-1:0] quo_p,
  output logic [bbct_pkg::TIME_W-1:0] quo_m,
  output logic ovf_p,
  output logic ovf_m,
  output bbct_pkg::div_side_t side_out
);
  import bbct_pkg::*;

  localparam int QBITS = TIME_W;
  localparam int NUM_W = NMAG_W + FRAC_BITS;
  localparam int REM_W = (NUM_W > DEN_W + QBITS) ? NUM_W : DEN_W + QBITS;
  localparam int NSTG = QBITS + 1;

  logic [REM_W-1:0] rem [2][NSTG];
  logic [REM_W-1:0] rem_next [2][NSTG];
  logic [QBITS-1:0] quo [2][NSTG];
  logic [QBITS-1:0] quo_next [2][NSTG];
  logic ovf [2][NSTG];
  logic ovf_next [2][NSTG];
  logic [DEN_W-1:0] dens [NSTG];
  div_side_t sides [NSTG];
  logic [NSTG-1:0] vld;

  always_comb begin
    logic [REM_W-1:0] init;
    logic [REM_W-1:0] dsh;
    for (int l = 0; l < 2; l++) begin
      init = (l == 0) ? (REM_W'(num_p) << FRAC_BITS) : (REM_W'(num_m) << FRAC_BITS);
      rem_next[l][0] = init;
      quo_next[l][0] = '0;
      ovf_next[l][0] = init >= (REM_W'(den) << QBITS);
      for (int k = 1; k < NSTG; k++) begin
        dsh = REM_W'(dens[k-1]) << (QBITS - k);
        if (rem[l][k-1] >= dsh) begin
          rem_next[l][k] = rem[l][k-1] - dsh;
          quo_next[l][k] = {quo[l][k-1][QBITS-2:0], 1'b1};
        end else begin
          rem_next[l][k] = rem[l][k-1];
          quo_next[l][k] = {quo[l][k-1][QBITS-2:0], 1'b0};
        end
        ovf_next[l][k] = ovf[l][k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        for (int k = 0; k < NSTG; k++) begin
          rem[l][k] <= rem_next[l][k];
          quo[l][k] <= quo_next[l][k];
          ovf[l][k] <= ovf_next[l][k];
        end
      end
      for (int k = 0; k < NSTG; k++) begin
        dens[k] <= (k == 0) ? den : dens[k-1];
        sides[k] <= (k == 0) ? side_in : sides[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTG-2:0], in_valid};
    end
  end

  assign out_valid = vld[NSTG-1];
  assign quo_p = quo[0][NSTG-1];
  assign quo_m = quo[1][NSTG-1];
  assign ovf_p = ovf[0][NSTG-1];
  assign ovf_m = ovf[1][NSTG-1];
  assign side_out = sides[NSTG-1];

endmodule

// File: hw/rtl/ball_ball_contact_time.sv
// Top level of the disc contact time block: front arithmetic, discriminant,
// root and divider pipelines and the acceptance stage.
// Depends on bbct_pkg, bbct_wmul, bbct_sqrt and bbct_div.
//
//   Channel  Signals                         Beat carries
//   in       in_valid / in_ready             two discs and the time limit
//   out      out_valid / out_ready           hit flag and contact time
//   cfg      cfg_wr_en, cfg_index, cfg_data  radius or touch tolerance
//
// One beat is accepted per cycle while the pipeline is not held; results pass
// through the 51-stage square root and then the 25-stage divider. Reset clears
// the valid bits and loads the register defaults. When a result waits on
// out_ready, the whole pipeline holds and in_ready stays low until it moves.
module ball_ball_contact_time #(
  parameter int FRAC_BITS = bbct_pkg::DEFAULT_FRAC_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_wr_en,
  input  logic [bbct_pkg::IDX_W-1:0] cfg_index,
  input  logic [bbct_pkg::REG_W-1:0] cfg_data,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [bbct_pkg::POS_W-1:0] first_pos_x,
  input  logic signed [bbct_pkg::POS_W-1:0] first_pos_y,
  input  logic signed [bbct_pkg::POS_W-1:0] first_vel_x,
  input  logic signed [bbct_pkg::POS_W-1:0] first_vel_y,
  input  logic signed [bbct_pkg::POS_W-1:0] second_pos_x,
  input  logic signed [bbct_pkg::POS_W-1:0] second_pos_y,
  input  logic signed [bbct_pkg::POS_W-1:0] second_vel_x,
  input  logic signed [bbct_pkg::POS_W-1:0] second_vel_y,
  input  logic [bbct_pkg::TIME_W-1:0] time_limit,
  output logic out_valid,
  input  logic out_ready,
  output logic hit,
  output logic [bbct_pkg::TIME_W-1:0] hit_time
);
  import bbct_pkg::*;

  logic [REG_W-1:0] radius, tol;
  logic en;
  logic v1, v2, v3, v4, v5, v6, v7, v8, v9, v10;

  logic signed [DIFF_W-1:0] dx1, dy1, vx1, vy1;
  logic [TIME_W-1:0] limit1, limit2, limit3, limit4, limit5, limit6, limit7, limit8;
  logic [TIME_W-1:0] limit9, limit10;
  logic signed [2*DIFF_W-1:0] sq_dx2, sq_dy2, sq_vx2, sq_vy2, pr_x2, pr_y2;
  logic [2*REG_W-1:0] rr2;
  logic [SQ_W-1:0] xx3, vv3, vv4, vv5, vv6, vv7, vv8;
  logic signed [DOT_W-1:0] p3;
  logic [2*REG_W+1:0] rr4_3;
  logic signed [A_W-1:0] a4;
  logic signed [C_W-1:0] c4, c5, c6, c7, c8;
  logic [AMAG_W-1:0] amag5;
  logic [CMAG_W-1:0] cmag5;
  logic apos5, apos6, apos7;
  logic vvnz5, vvnz6, vvnz7;
  logic [PROD_W-1:0] av7, cc7, av4x;
  logic [PROD_W:0] d_sum;
  logic [PROD_W-1:0] d_dif;
  logic [D_W-1:0] d8, d8_next;
  logic roots8, roots8_next;

  logic sq_valid;
  logic [S_W-1:0] sq_root;
  sqrt_side_t sq_side;
  logic signed [N_W-1:0] c_ext, s_ext, np9, nm9;
  logic [DEN_W-1:0] den9, den10;
  logic roots9, roots10;
  logic [NMAG_W-1:0] magp10, magm10;
  logic negp10, negm10;

  logic dv_valid;
  logic [TIME_W-1:0] quo_p, quo_m;
  logic ovf_p, ovf_m;
  div_side_t dv_side;
  logic ok_p, ok_m;
  logic [TIME_W-1:0] lim_mid;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
      tol <= TOL_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_DISC_RADIUS: radius <= cfg_data;
        REG_TOUCH_TOL: tol <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
      v9 <= 1'b0;
      v10 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
      v8 <= v7;
      v9 <= sq_valid;
      v10 <= v9;
    end
  end

  always_comb begin
    av4x = {av7[PROD_W-3:0], 2'b00};
    d_sum = {1'b0, cc7} + {1'b0, av4x};
    d_dif = cc7 - av4x;
    if (!apos7) begin
      d8_next = D_W'(d_sum);
      roots8_next = vvnz7;
    end else if (av4x <= cc7) begin
      d8_next = D_W'(d_dif);
      roots8_next = vvnz7;
    end else begin
      d8_next = '0;
      roots8_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx1 <= DIFF_W'(second_pos_x) - DIFF_W'(first_pos_x);
      dy1 <= DIFF_W'(second_pos_y) - DIFF_W'(first_pos_y);
      vx1 <= DIFF_W'(second_vel_x) - DIFF_W'(first_vel_x);
      vy1 <= DIFF_W'(second_vel_y) - DIFF_W'(first_vel_y);
      limit1 <= time_limit;

      sq_dx2 <= dx1 * dx1;
      sq_dy2 <= dy1 * dy1;
      sq_vx2 <= vx1 * vx1;
      sq_vy2 <= vy1 * vy1;
      pr_x2 <= dx1 * vx1;
      pr_y2 <= dy1 * vy1;
      rr2 <= radius * radius;
      limit2 <= limit1;

      xx3 <= SQ_W'(sq_dx2) + SQ_W'(sq_dy2);
      vv3 <= SQ_W'(sq_vx2) + SQ_W'(sq_vy2);
      p3 <= pr_x2 + pr_y2;
      rr4_3 <= {rr2, 2'b00};
      limit3 <= limit2;

      a4 <= $signed({1'b0, xx3}) - $signed({2'b00, rr4_3});
      c4 <= -$signed({p3, 1'b0});
      vv4 <= vv3;
      limit4 <= limit3;

      amag5 <= a4[A_W-1] ? AMAG_W'(-a4) : AMAG_W'(a4);
      cmag5 <= c4[C_W-1] ? CMAG_W'(-c4) : CMAG_W'(c4);
      apos5 <= a4 > 0;
      vvnz5 <= vv4 != '0;
      vv5 <= vv4;
      c5 <= c4;
      limit5 <= limit4;

      apos6 <= apos5;
      vvnz6 <= vvnz5;
      vv6 <= vv5;
      c6 <= c5;
      limit6 <= limit5;

      apos7 <= apos6;
      vvnz7 <= vvnz6;
      vv7 <= vv6;
      c7 <= c6;
      limit7 <= limit6;

      d8 <= d8_next;
      roots8 <= roots8_next;
      vv8 <= vv7;
      c8 <= c7;
      limit8 <= limit7;

      np9 <= c_ext + s_ext;
      nm9 <= c_ext - s_ext;
      den9 <= {sq_side.vv, 1'b0};
      limit9 <= sq_side.limit;
      roots9 <= sq_side.has_roots;

      magp10 <= np9[N_W-1] ? NMAG_W'(-np9) : NMAG_W'(np9);
      magm10 <= nm9[N_W-1] ? NMAG_W'(-nm9) : NMAG_W'(nm9);
      negp10 <= np9[N_W-1];
      negm10 <= nm9[N_W-1];
      den10 <= den9;
      limit10 <= limit9;
      roots10 <= roots9;
    end
  end

  bbct_wmul u_mul_av (
    .clk(clk),
    .en(en),
    .a(MUL_W'(amag5)),
    .b(MUL_W'(vv5)),
    .p(av7)
  );

  bbct_wmul u_mul_cc (
    .clk(clk),
    .en(en),
    .a(cmag5),
    .b(cmag5),
    .p(cc7)
  );

  bbct_sqrt u_sqrt (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_valid(v8),
    .d_in(d8),
    .side_in('{c: c8, vv: vv8, limit: limit8, has_roots: roots8}),
    .out_valid(sq_valid),
    .root(sq_root),
    .side_out(sq_side)
  );

  assign c_ext = N_W'($signed(sq_side.c));
  assign s_ext = $signed(N_W'(sq_root));

  bbct_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_valid(v10),
    .num_p(magp10),
    .num_m(magm10),
    .den(den10),
    .side_in('{limit: limit10, has_roots: roots10, neg_p: negp10, neg_m: negm10}),
    .out_valid(dv_valid),
    .quo_p(quo_p),
    .quo_m(quo_m),
    .ovf_p(ovf_p),
    .ovf_m(ovf_m),
    .side_out(dv_side)
  );

  always_comb begin
    ok_p = dv_side.has_roots && !ovf_p &&
           (dv_side.neg_p ? (quo_p < TIME_W'(tol)) : (quo_p < dv_side.limit));
    lim_mid = ok_p ? quo_p : dv_side.limit;
    ok_m = dv_side.has_roots && !ovf_m &&
           (dv_side.neg_m ? (quo_m < TIME_W'(tol)) : (quo_m < lim_mid));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit <= ok_p || ok_m;
      hit_time <= ok_m ? quo_m : lim_mid;
    end
  end

endmodule

// File: bench/tb.sv
// Self-checking bench for ball_ball_contact_time: random and directed disc pairs,
// a bit-exact contact time predictor and random stalls on both channels.
// Depends on bbct_pkg and the ball_ball_contact_time RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bbct_pkg::*;

  typedef struct {
    logic signed [POS_W-1:0] p1x, p1y, v1x, v1y, p2x, p2y, v2x, v2y;
    logic [TIME_W-1:0] limit;
  } disc_pair_t;

  typedef struct {
    logic hit;
    logic [TIME_W-1:0] when;
  } contact_t;

  localparam int WATCHDOG_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [IDX_W-1:0] cfg_index = REG_DISC_RADIUS;
  logic [REG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [POS_W-1:0] first_pos_x = '0, first_pos_y = '0;
  logic signed [POS_W-1:0] first_vel_x = '0, first_vel_y = '0;
  logic signed [POS_W-1:0] second_pos_x = '0, second_pos_y = '0;
  logic signed [POS_W-1:0] second_vel_x = '0, second_vel_y = '0;
  logic [TIME_W-1:0] time_limit = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic hit;
  logic [TIME_W-1:0] hit_time;

  disc_pair_t pending_pairs[$];
  contact_t expected_contacts[$];
  logic [REG_W-1:0] radius_q = RADIUS_RESET;
  logic [REG_W-1:0] tolerance_q = TOL_RESET;
  logic in_took = 1'b0;
  bit calm = 1'b0;
  int mismatches = 0;
  int quiet_cycles = 0;

  ball_ball_contact_time dut (.*);

  always #1 clk = ~clk;

  function automatic contact_t contact_time(disc_pair_t p, logic [REG_W-1:0] rad,
                                            logic [REG_W-1:0] tol);
    longint dx, dy, vx, vy, xx, vv, a, c, s, num;
    logic [63:0] lim, cmag, amag, mag, q, cand;
    logic [127:0] cc, av, d, q128;
    bit roots;
    contact_t r;
    dx = longint'(p.p2x) - longint'(p.p1x);
    dy = longint'(p.p2y) - longint'(p.p1y);
    vx = longint'(p.v2x) - longint'(p.v1x);
    vy = longint'(p.v2y) - longint'(p.v1y);
    lim = 64'(p.limit);
    r.hit = 1'b0;
    xx = dx * dx + dy * dy;
    vv = vx * vx + vy * vy;
    a = xx - 4 * longint'(rad) * longint'(rad);
    c = -2 * (dx * vx + dy * vy);
    if (vv != 0) begin
      cmag = (c < 0) ? -c : c;
      amag = (a < 0) ? -a : a;
      cc = 128'(cmag) * 128'(cmag);
      av = (128'(amag) * 128'(vv)) << 2;
      roots = 1'b1;
      d = '0;
      if (a <= 0) d = cc + av;
      else if (av <= cc) d = cc - av;
      else roots = 1'b0;
      if (roots) begin
        s = 0;
        for (int b = 52; b >= 0; b--) begin
          cand = 64'(s) | (64'd1 << b);
          if (128'(cand) * 128'(cand) <= d) s = longint'(cand);
        end
        for (int k = 0; k < 2; k++) begin
          num = (k == 0) ? c + s : c - s;
          mag = (num < 0) ? -num : num;
          q128 = (128'(mag) << DEFAULT_FRAC_BITS) / (128'(vv) << 1);
          q = (|q128[127:64]) ? '1 : q128[63:0];
          if ((num >= 0) ? (q < lim) : (q < 64'(tol))) begin
            lim = q;
            r.hit = 1'b1;
          end
        end
      end
    end
    r.when = lim[TIME_W-1:0];
    return r;
  endfunction

  function automatic logic signed [POS_W-1:0] rnd_signed(int bits);
    return POS_W'($signed($urandom_range(0, (1 << (bits + 1)) - 1)) - (1 << bits));
  endfunction

  function automatic disc_pair_t make_pair(int mode);
    disc_pair_t p;
    logic signed [POS_W-1:0] dx, dy;
    int k;
    p.p1x = POS_W'($urandom); p.p1y = POS_W'($urandom);
    p.v1x = POS_W'($urandom); p.v1y = POS_W'($urandom);
    p.p2x = POS_W'($urandom); p.p2y = POS_W'($urandom);
    p.v2x = POS_W'($urandom); p.v2y = POS_W'($urandom);
    p.limit = ($urandom_range(0, 3) == 0) ? '1 : TIME_W'($urandom);
    if (mode != 0) begin
      p.p1x = rnd_signed(20); p.p1y = rnd_signed(20);
      p.v1x = rnd_signed(18); p.v1y = rnd_signed(18);
      dx = rnd_signed((mode == 3) ? 15 : 17);
      dy = rnd_signed((mode == 3) ? 15 : 17);
      p.p2x = p.p1x + dx; p.p2y = p.p1y + dy;
      k = $urandom_range(0, 6);
      p.v2x = p.v1x - (dx >>> k) + rnd_signed(10);
      p.v2y = p.v1y - (dy >>> k) + rnd_signed(10);
      if (mode == 2) begin
        p.v2x = p.v1x; p.v2y = p.v1y;
      end
    end
    return p;
  endfunction

  function automatic disc_pair_t shaped(int ox, int oy, int vx, int vy,
                                        logic [TIME_W-1:0] lim);
    disc_pair_t p;
    p.p1x = '0; p.p1y = '0; p.v1x = '0; p.v1y = '0;
    p.p2x = POS_W'(ox); p.p2y = POS_W'(oy); p.v2x = POS_W'(vx); p.v2y = POS_W'(vy);
    p.limit = lim;
    return p;
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [REG_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic drain();
    wait (pending_pairs.size() == 0 && !in_valid && expected_contacts.size() == 0);
    repeat (100) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (!rst && (!in_valid || in_took)) begin
      if (pending_pairs.size() != 0 && (calm || $urandom_range(0, 99) >= 32)) begin
        disc_pair_t p;
        p = pending_pairs.pop_front();
        first_pos_x <= p.p1x; first_pos_y <= p.p1y;
        first_vel_x <= p.v1x; first_vel_y <= p.v1y;
        second_pos_x <= p.p2x; second_pos_y <= p.p2y;
        second_vel_x <= p.v2x; second_vel_y <= p.v2y;
        time_limit <= p.limit;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= calm || $urandom_range(0, 99) >= 32;
  end

  always @(posedge clk) begin
    disc_pair_t p;
    contact_t want;
    in_took <= in_valid && in_ready;
    if (cfg_wr_en) begin
      if (cfg_index == REG_DISC_RADIUS) radius_q <= cfg_data;
      else tolerance_q <= cfg_data;
    end
    if (!rst && in_valid && in_ready) begin
      p.p1x = first_pos_x; p.p1y = first_pos_y; p.v1x = first_vel_x; p.v1y = first_vel_y;
      p.p2x = second_pos_x; p.p2y = second_pos_y;
      p.v2x = second_vel_x; p.v2y = second_vel_y;
      p.limit = time_limit;
      expected_contacts.push_back(contact_time(p, radius_q, tolerance_q));
    end
    if (!rst && out_valid && out_ready) begin
      if (expected_contacts.size() == 0) begin
        $display("%0t: unexpected beat hit=%0b hit_time=%0h", $time, hit, hit_time);
        mismatches++;
      end else begin
        want = expected_contacts.pop_front();
        if (hit !== want.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, want.hit, hit);
          mismatches++;
        end
        if (hit_time !== want.when) begin
          $display("%0t: hit_time expected %0h actual %0h", $time, want.when, hit_time);
          mismatches++;
        end
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)
        || (pending_pairs.size() == 0 && !in_valid && expected_contacts.size() == 0))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    logic [REG_W-1:0] radii[5];
    logic [REG_W-1:0] tols[5];
    int r2;
    radii = '{23'd40960, 23'd0, 23'h7FFFFF, 23'd40960, 23'd4096};
    tols = '{23'd4, 23'd0, 23'h7FFFFF, 23'd300, 23'd4};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 4) begin
        radii[ph] = 23'($urandom_range(1, 200000));
        tols[ph] = 23'($urandom_range(0, 5000));
      end
      write_reg(REG_DISC_RADIUS, radii[ph]);
      write_reg(REG_TOUCH_TOL, tols[ph]);
      r2 = 2 * int'(radii[ph] > 23'h100000 ? 23'd40960 : radii[ph]);
      if (ph == 0) begin
        pending_pairs.push_back(shaped(8388607, 8388607, 8388607, 8388607, '1));
        pending_pairs.push_back(shaped(-8388608, -8388608, -8388608, -8388608, '1));
        pending_pairs.push_back(shaped(100000, 0, 0, 0, '1));
        pending_pairs.push_back(shaped(200000, 0, -4096, 0, '1));
        pending_pairs.push_back(shaped(200000, 0, -4096, 0, '0));
        pending_pairs.push_back(shaped(200000, 0, 4096, 0, '1));
        pending_pairs.push_back(shaped(10000, 0, 4096, 0, '1));
        pending_pairs.push_back(shaped(10000, 0, -4096, 0, '1));
        pending_pairs.push_back(shaped(-50000, r2, 4096, 0, '1));
        pending_pairs.push_back(shaped(r2, 0, -4096, 0, '1));
        pending_pairs.push_back(shaped(r2, 0, 4096, 0, '1));
        pending_pairs.push_back(shaped(0, 300000, 0, 1, '1));
        pending_pairs.push_back(shaped(r2 - 2, 0, 8388607, 0, '1));
        pending_pairs.push_back(shaped(200000, 0, -1, 0, 24'd1000));
        pending_pairs.push_back(shaped(0, 0, 0, 0, 24'd5));
        pending_pairs.push_back(shaped(-8388608, 8388607, -8388608, 8388607, '0));
      end
      for (int i = 0; i < 230; i++) begin
        r2 = $urandom_range(0, 99);
        pending_pairs.push_back(make_pair(r2 < 15 ? 0 : r2 < 75 ? 1 : r2 < 82 ? 2 : 3));
      end
      calm = (ph == 2);
      drain();
    end
    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: ball_ball_contact_time.f
hw/rtl/bbct_pkg.sv
hw/rtl/bbct_wmul.sv
hw/rtl/bbct_sqrt.sv
hw/rtl/bbct_div.sv
hw/rtl/ball_ball_contact_time.sv
bench/tb.sv
